/* src/mla_pkg.sv */
// Shared types, constants and register indexes of the mipmap level address table.
package mla_pkg;

    localparam int MAX_LEVEL   = 8;
    localparam int TOP_LOG2    = 8;
    localparam int LEVEL_W     = 4;
    localparam int NUM_TERMS   = MAX_LEVEL + 2;
    localparam int EXP_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int MASK_W      = 8;
    localparam int SHIFT_W     = 4;
    localparam int TOPW_W      = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int ASPECT_W    = 2;
    localparam int FLAGS_W     = 6;

    localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = LEVEL_W'(MAX_LEVEL + 1);
    localparam logic [LEVEL_W-1:0] TOP_EXP     = LEVEL_W'(TOP_LOG2);

    localparam logic [CFG_IDX_W-1:0] REG_ASPECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TWO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_REST = 3'd5;

    localparam int FLG_S_WIDE = 0;
    localparam int FLG_SPLIT  = 1;
    localparam int FLG_ODD    = 2;
    localparam int FLG_MULTI  = 3;
    localparam int FLG_TRI    = 4;
    localparam int FLG_WIDE16 = 5;

    typedef struct packed {
        logic [ASPECT_W-1:0] aspect_ratio;
        logic [FLAGS_W-1:0]  level_flags;
        logic [ADDR_W-1:0]   base_zero;
        logic [ADDR_W-1:0]   base_one;
        logic [ADDR_W-1:0]   base_two;
        logic [ADDR_W-1:0]   base_rest;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  level_start;
        logic [ADDR_W-1:0]  level_stop;
        logic [MASK_W-1:0]  width_mask;
        logic [MASK_W-1:0]  height_mask;
        logic [SHIFT_W-1:0] row_shift;
        logic [LEVEL_W-1:0] source_level;
        logic [TOPW_W-1:0]  top_width;
    } t_desc;

endpackage

/* src/mla_cfg_regs.sv */
// Configuration register file of the mipmap level address table.
module mla_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [mla_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mla_pkg::ADDR_W-1:0]   i_cfg_data,
    output mla_pkg::t_cfg                o_cfg
);
    import mla_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ASPECT:    n_cfg.aspect_ratio = i_cfg_data[ASPECT_W-1:0];
                REG_FLAGS:     n_cfg.level_flags  = i_cfg_data[FLAGS_W-1:0];
                REG_BASE_ZERO: n_cfg.base_zero    = i_cfg_data;
                REG_BASE_ONE:  n_cfg.base_one     = i_cfg_data;
                REG_BASE_TWO:  n_cfg.base_two     = i_cfg_data;
                REG_BASE_REST: n_cfg.base_rest    = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/mla_level_calc.sv */
// Combinational descriptor computation for one requested mipmap level.
module mla_level_calc (
    input  mla_pkg::t_cfg               i_cfg,
    input  logic [mla_pkg::LEVEL_W-1:0] i_level,
    output mla_pkg::t_desc              o_desc
);
    import mla_pkg::*;

    logic               s_wide, split, odd, multi, tri_en, wide16;
    logic [LEVEL_W-1:0] req;
    logic [LEVEL_W-1:0] req_inc;
    logic [LEVEL_W-1:0] src;
    logic [LEVEL_W-1:0] ew, eh, ewf, ehf;
    logic [ADDR_W-1:0]  off;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  start;
    logic [EXP_W-1:0]   size_exp;
    logic [TOPW_W-1:0]  w_full, h_full;

    assign s_wide = i_cfg.level_flags[FLG_S_WIDE];
    assign split  = i_cfg.level_flags[FLG_SPLIT];
    assign odd    = i_cfg.level_flags[FLG_ODD];
    assign multi  = i_cfg.level_flags[FLG_MULTI];
    assign tri_en = i_cfg.level_flags[FLG_TRI];
    assign wide16 = i_cfg.level_flags[FLG_WIDE16];

    assign req     = (i_level > LEVEL_LIMIT) ? LEVEL_LIMIT : i_level;
    assign req_inc = req + LEVEL_W'(1);

    // Trilinear mode steps by two and counts only levels of one parity.
    always_comb begin
        priority if (!tri_en) begin
            src = (odd && req != '0) ? req - LEVEL_W'(1) : req;
        end else if (odd) begin
            src = {req[LEVEL_W-1:1], 1'b1};
        end else begin
            src = {req_inc[LEVEL_W-1:1], 1'b0};
        end
    end

    assign ew = s_wide ? TOP_EXP : TOP_EXP - LEVEL_W'(i_cfg.aspect_ratio);
    assign eh = s_wide ? TOP_EXP - LEVEL_W'(i_cfg.aspect_ratio) : TOP_EXP;

    // Every level size is a distinct power of two, so each term is a single bit
    // and the terms are merged without any carries.
    always_comb begin
        off = '0;
        for (int j = 0; j < NUM_TERMS; j++) begin
            if ((LEVEL_W'(j) < src) && (!split || (j[0] == odd))
                    && (LEVEL_W'(j) <= ew) && (LEVEL_W'(j) <= eh)) begin
                off = off | (ADDR_W'(1) << (EXP_W'(ew) + EXP_W'(eh) + EXP_W'(wide16)
                                            - EXP_W'(2 * j)));
            end
        end
    end

    always_comb begin
        if (multi) begin
            unique case (src)
                LEVEL_W'(0): base = i_cfg.base_zero;
                LEVEL_W'(1): base = i_cfg.base_one;
                LEVEL_W'(2): base = i_cfg.base_two;
                default:     base = i_cfg.base_rest;
            endcase
        end else begin
            base = i_cfg.base_zero;
        end
    end

    assign ewf      = (src >= ew) ? '0 : ew - src;
    assign ehf      = (src >= eh) ? '0 : eh - src;
    assign size_exp = EXP_W'(ewf) + EXP_W'(ehf) + EXP_W'(wide16);
    assign w_full   = (TOPW_W'(1) << ewf) - TOPW_W'(1);
    assign h_full   = (TOPW_W'(1) << ehf) - TOPW_W'(1);
    assign start    = base + off;

    always_comb begin
        o_desc.level_start  = start;
        o_desc.level_stop   = start + (ADDR_W'(1) << size_exp);
        o_desc.width_mask   = w_full[MASK_W-1:0];
        o_desc.height_mask  = h_full[MASK_W-1:0];
        o_desc.row_shift    = SHIFT_W'(ewf);
        o_desc.source_level = src;
        o_desc.top_width    = TOPW_W'(1) << ew;
    end

endmodule

/* src/mip_level_address_table.sv */
// Top level of the mipmap level address table.
//
// A requested mipmap level enters on the input channel (i_valid, o_ready,
// i_level_index) and its memory descriptor leaves on the output channel
// (o_valid, i_ready, o_level_*). Indexes above the last level plus one are
// saturated. Configuration registers are written through their own channel,
// which is always ready; they may only change while no beat is in flight.
// A beat is captured in an input register, the descriptor is computed by
// shift-and-add logic, and the result is held in an output register, which
// drives o_valid once the beat has passed through the input register. While
// the receiver does not stall, one beat is taken every cycle; the throughput
// is set by the single pass through the descriptor logic between the two
// registers. When the receiver stalls, the output register holds its beat and
// the input register still accepts one more beat before o_ready falls. Reset
// empties both registers and clears all configuration registers to zero.
module mip_level_address_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mla_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mla_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mla_pkg::LEVEL_W-1:0]   i_level_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mla_pkg::ADDR_W-1:0]    o_level_start,
    output logic [mla_pkg::ADDR_W-1:0]    o_level_stop,
    output logic [mla_pkg::MASK_W-1:0]    o_width_mask,
    output logic [mla_pkg::MASK_W-1:0]    o_height_mask,
    output logic [mla_pkg::SHIFT_W-1:0]   o_row_shift,
    output logic [mla_pkg::LEVEL_W-1:0]   o_source_level,
    output logic [mla_pkg::TOPW_W-1:0]    o_top_width
);
    import mla_pkg::*;

    t_cfg               cfg;
    t_desc              desc;
    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_level;
    logic               r_out_valid;
    t_desc              r_desc;
    logic               out_ready;
    logic               in_ready;

    assign o_cfg_ready = 1'b1;

    mla_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mla_level_calc u_calc (
        .i_cfg   (cfg),
        .i_level (r_level),
        .o_desc  (desc)
    );

    assign out_ready = !r_out_valid || i_ready;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_ready   = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_level <= i_level_index;
        end
        if (out_ready && r_in_valid) begin
            r_desc <= desc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_level_start  = r_desc.level_start;
    assign o_level_stop   = r_desc.level_stop;
    assign o_width_mask   = r_desc.width_mask;
    assign o_height_mask  = r_desc.height_mask;
    assign o_row_shift    = r_desc.row_shift;
    assign o_source_level = r_desc.source_level;
    assign o_top_width    = r_desc.top_width;

endmodule

/* src/mla_checker.sv */
// Port-level assertions for the mipmap level address table, with their bind.
module mla_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [mla_pkg::ADDR_W-1:0]    o_level_start,
    input logic [mla_pkg::ADDR_W-1:0]    o_level_stop,
    input logic [mla_pkg::MASK_W-1:0]    o_width_mask,
    input logic [mla_pkg::SHIFT_W-1:0]   o_row_shift,
    input logic [mla_pkg::LEVEL_W-1:0]   o_source_level
);
    import mla_pkg::*;

    logic [TOPW_W-1:0] row_width;
    logic [ADDR_W-1:0] level_size;

    assign row_width  = (TOPW_W'(1) << o_row_shift) - TOPW_W'(1);
    assign level_size = o_level_stop - o_level_start;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output beat present right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_level_start)
                                && $stable(o_source_level))
        else $error("Stalled output beat changed.");

    a_mask_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_width_mask == row_width[MASK_W-1:0])
        else $error("Width mask disagrees with row shift.");

    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(level_size))
        else $error("Level size is not a power of two.");

    a_src_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_source_level <= LEVEL_W'(MAX_LEVEL + 2))
        else $error("Source level out of range.");

endmodule

bind mip_level_address_table mla_checker u_mla_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_level_start  (o_level_start),
    .o_level_stop   (o_level_stop),
    .o_width_mask   (o_width_mask),
    .o_row_shift    (o_row_shift),
    .o_source_level (o_source_level)
);

/* bench/tb_top.sv */
// Self-checking testbench of the mipmap level address table: directed table, random lookups.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mla_pkg::*;

    localparam int SETTINGS_PER_PHASE = 8;
    localparam int ITEMS_PER_SETTING  = 67;
    localparam int END_SETTLE         = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [FLAGS_W-1:0] FLAGS_NONE      = '0;
    localparam logic [FLAGS_W-1:0] FLAGS_ALL       = '1;
    localparam logic [FLAGS_W-1:0] FLAGS_S_WIDE    = FLAGS_W'(1 << FLG_S_WIDE);
    localparam logic [FLAGS_W-1:0] FLAGS_TRI_ODD   = FLAGS_W'((1 << FLG_SPLIT) | (1 << FLG_ODD)
                                                     | (1 << FLG_TRI) | (1 << FLG_WIDE16));
    localparam logic [FLAGS_W-1:0] FLAGS_ODD_MULTI = FLAGS_W'((1 << FLG_ODD) | (1 << FLG_MULTI));

    typedef enum logic {ROW_WRITE, ROW_LOOKUP} row_kind_e;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [ADDR_W-1:0]      data;
        logic [LEVEL_W-1:0]     level;
        bit                     typed;
        t_desc                  desc;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [LEVEL_W-1:0]   i_level_index;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [ADDR_W-1:0]    o_level_start;
    logic [ADDR_W-1:0]    o_level_stop;
    logic [MASK_W-1:0]    o_width_mask;
    logic [MASK_W-1:0]    o_height_mask;
    logic [SHIFT_W-1:0]   o_row_shift;
    logic [LEVEL_W-1:0]   o_source_level;
    logic [TOPW_W-1:0]    o_top_width;

    t_cfg       cfg_shadow;
    t_desc      desc_queue[$];
    stim_row_t  stim_rows[$];
    t_desc      next_typed_desc;
    t_desc      got_desc;
    bit         next_typed;
    int         failures;
    int         lookups_seen;
    int         writes_seen;
    int         settings_done;
    int         send_idle;
    int         recv_idle;

    mip_level_address_table uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_level_index  (i_level_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_level_start  (o_level_start),
        .o_level_stop   (o_level_stop),
        .o_width_mask   (o_width_mask),
        .o_height_mask  (o_height_mask),
        .o_row_shift    (o_row_shift),
        .o_source_level (o_source_level),
        .o_top_width    (o_top_width)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_desc predict_level(input logic [LEVEL_W-1:0] level_in, input t_cfg c);
        logic [LEVEL_W-1:0] level;
        logic               odd_mode;
        logic               trilin;
        logic               split_mode;
        logic [ADDR_W-1:0]  bpp;
        logic [ADDR_W-1:0]  w0;
        logic [ADDR_W-1:0]  h0;
        logic [ADDR_W-1:0]  offset;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  w;
        logic [ADDR_W-1:0]  h;
        logic [ADDR_W-1:0]  start;
        int                 sh0;
        int                 src;
        int                 sh;
        t_desc              d;
        level      = (level_in > LEVEL_LIMIT) ? LEVEL_LIMIT : level_in;
        odd_mode   = c.level_flags[FLG_ODD];
        trilin     = c.level_flags[FLG_TRI];
        split_mode = c.level_flags[FLG_SPLIT];
        bpp        = c.level_flags[FLG_WIDE16] ? 32'd2 : 32'd1;
        w0         = 32'd1 << TOP_LOG2;
        h0         = 32'd1 << TOP_LOG2;
        sh0        = TOP_LOG2;
        if (c.level_flags[FLG_S_WIDE]) begin
            h0 = h0 >> c.aspect_ratio;
        end else begin
            w0  = w0 >> c.aspect_ratio;
            sh0 = sh0 - int'(c.aspect_ratio);
        end
        src = (trilin && odd_mode) ? 1 : 0;
        for (int l = 0; l < int'(level); l++) begin
            if (!trilin || ((l % 2 == 1) == odd_mode)) begin
                if (!odd_mode || l != 0) begin
                    src += trilin ? 2 : 1;
                end
            end
        end
        offset = '0;
        for (int j = 0; j < src; j++) begin
            if (!split_mode || ((j % 2 == 1) == odd_mode)) begin
                offset += (w0 >> j) * (h0 >> j) * bpp;
            end
        end
        if (c.level_flags[FLG_MULTI]) begin
            case (src)
                0:       base = c.base_zero;
                1:       base = c.base_one;
                2:       base = c.base_two;
                default: base = c.base_rest;
            endcase
        end else begin
            base = c.base_zero;
        end
        w = w0 >> src;
        if (w == 0) begin
            w = 1;
        end
        h = h0 >> src;
        if (h == 0) begin
            h = 1;
        end
        sh = (src >= sh0) ? 0 : sh0 - src;
        start          = base + offset;
        d.level_start  = start;
        d.level_stop   = start + w * h * bpp;
        d.width_mask   = MASK_W'(w - 1);
        d.height_mask  = MASK_W'(h - 1);
        d.row_shift    = SHIFT_W'(sh);
        d.source_level = LEVEL_W'(src);
        d.top_width    = TOPW_W'(w0);
        return d;
    endfunction

    function automatic t_desc make_desc(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop,
                                        input logic [MASK_W-1:0] wmask, input logic [MASK_W-1:0] hmask,
                                        input logic [SHIFT_W-1:0] shift, input logic [LEVEL_W-1:0] src,
                                        input logic [TOPW_W-1:0] topw);
        t_desc d;
        d.level_start  = start;
        d.level_stop   = stop;
        d.width_mask   = wmask;
        d.height_mask  = hmask;
        d.row_shift    = shift;
        d.source_level = src;
        d.top_width    = topw;
        return d;
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        if ($urandom_range(99) < 85) begin
            return LEVEL_W'($urandom_range(MAX_LEVEL + 1));
        end
        return LEVEL_W'($urandom_range(15, MAX_LEVEL + 2));
    endfunction

    function automatic logic [ADDR_W-1:0] random_base();
        case ($urandom_range(3))
            0:       return 32'hffff_ffff - $urandom_range(200000);
            1:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic field_check(input string name, input logic [ADDR_W-1:0] exp_val,
                               input logic [ADDR_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            failures++;
        end
    endtask

    task automatic check_desc(input t_desc exp_d, input t_desc act_d);
        field_check("level_start", exp_d.level_start, act_d.level_start);
        field_check("level_stop", exp_d.level_stop, act_d.level_stop);
        field_check("width_mask", ADDR_W'(exp_d.width_mask), ADDR_W'(act_d.width_mask));
        field_check("height_mask", ADDR_W'(exp_d.height_mask), ADDR_W'(act_d.height_mask));
        field_check("row_shift", ADDR_W'(exp_d.row_shift), ADDR_W'(act_d.row_shift));
        field_check("source_level", ADDR_W'(exp_d.source_level), ADDR_W'(act_d.source_level));
        field_check("top_width", ADDR_W'(exp_d.top_width), ADDR_W'(act_d.top_width));
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        case (idx)
            REG_ASPECT:    cfg_shadow.aspect_ratio = data[ASPECT_W-1:0];
            REG_FLAGS:     cfg_shadow.level_flags  = data[FLAGS_W-1:0];
            REG_BASE_ZERO: cfg_shadow.base_zero    = data;
            REG_BASE_ONE:  cfg_shadow.base_one     = data;
            REG_BASE_TWO:  cfg_shadow.base_two     = data;
            REG_BASE_REST: cfg_shadow.base_rest    = data;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
                writes_seen++;
            end
            if (i_valid && o_ready) begin
                desc_queue.push_back(next_typed ? next_typed_desc
                                                : predict_level(i_level_index, cfg_shadow));
                lookups_seen++;
            end
            if (o_valid && i_ready) begin
                got_desc = {o_level_start, o_level_stop, o_width_mask, o_height_mask,
                            o_row_shift, o_source_level, o_top_width};
                if (desc_queue.size() == 0) begin
                    $error("descriptor beat with no lookup outstanding");
                    failures++;
                end else begin
                    check_desc(desc_queue.pop_front(), got_desc);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_level(input logic [LEVEL_W-1:0] level, input bit typed, input t_desc desc);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_level_index   <= level;
        next_typed      = typed;
        next_typed_desc = desc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (desc_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        stim_row_t r;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.data      = data;
        r.level     = '0;
        r.typed     = 1'b0;
        r.desc      = '0;
        stim_rows.push_back(r);
    endtask

    task automatic add_lookup(input logic [LEVEL_W-1:0] level, input bit typed, input t_desc desc);
        stim_row_t r;
        r.kind      = ROW_LOOKUP;
        r.reg_index = '0;
        r.data      = '0;
        r.level     = level;
        r.typed     = typed;
        r.desc      = desc;
        stim_rows.push_back(r);
    endtask

    task automatic program_setting(input int s);
        logic [ASPECT_W-1:0] aspect;
        logic [FLAGS_W-1:0]  flags;
        if (s == 0) begin
            write_reg(REG_ASPECT, ADDR_W'(2'd3));
            write_reg(REG_FLAGS, ADDR_W'(FLAGS_ALL));
            write_reg(REG_BASE_ZERO, '1);
            write_reg(REG_BASE_ONE, '1);
            write_reg(REG_BASE_TWO, '1);
            write_reg(REG_BASE_REST, '1);
        end else if (s == 1) begin
            write_reg(REG_ASPECT, '0);
            write_reg(REG_FLAGS, ADDR_W'(FLAGS_NONE));
            write_reg(REG_BASE_ZERO, '0);
            write_reg(REG_BASE_ONE, '0);
            write_reg(REG_BASE_TWO, '0);
            write_reg(REG_BASE_REST, '0);
        end else begin
            aspect = ASPECT_W'($urandom_range(3));
            flags  = FLAGS_W'($urandom_range(63));
            write_reg(REG_ASPECT, ADDR_W'(aspect));
            write_reg(REG_FLAGS, ADDR_W'(flags));
            write_reg(REG_BASE_ZERO, random_base());
            write_reg(REG_BASE_ONE, random_base());
            write_reg(REG_BASE_TWO, random_base());
            write_reg(REG_BASE_REST, random_base());
        end
        if ($urandom_range(1)) begin
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        end
    endtask

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_level_index   = '0;
        cfg_shadow      = '0;
        next_typed      = 1'b0;
        next_typed_desc = '0;
        failures        = 0;
        lookups_seen    = 0;
        writes_seen     = 0;
        settings_done   = 0;
        send_idle       = 23;
        recv_idle       = 45;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_lookup(4'd0, 1'b1, make_desc(0, 65536, 255, 255, 8, 0, 256));
        add_lookup(4'd1, 1'b1, make_desc(65536, 81920, 127, 127, 7, 1, 256));
        add_lookup(4'd15, 1'b1, make_desc(87381, 87382, 0, 0, 0, 9, 256));
        add_lookup(4'd9, 1'b0, '0);
        add_lookup(4'd8, 1'b0, '0);
        add_write(REG_SPARE_HI, '1);
        add_write(REG_SPARE_LO, '1);
        add_lookup(4'd0, 1'b1, make_desc(0, 65536, 255, 255, 8, 0, 256));
        add_write(REG_ASPECT, ADDR_W'(2'd3));
        add_lookup(4'd0, 1'b1, make_desc(0, 8192, 31, 255, 5, 0, 32));
        add_lookup(4'd5, 1'b0, '0);
        add_write(REG_FLAGS, ADDR_W'(FLAGS_S_WIDE));
        add_lookup(4'd0, 1'b1, make_desc(0, 8192, 255, 31, 8, 0, 256));
        add_lookup(4'd15, 1'b0, '0);
        add_write(REG_BASE_ZERO, '1);
        add_write(REG_FLAGS, ADDR_W'(FLAGS_TRI_ODD));
        add_lookup(4'd0, 1'b0, '0);
        add_lookup(4'd9, 1'b0, '0);
        add_write(REG_FLAGS, ADDR_W'(FLAGS_ODD_MULTI));
        add_write(REG_BASE_ONE, 32'h1000_0000);
        add_write(REG_BASE_TWO, 32'h2000_0000);
        add_write(REG_BASE_REST, 32'hf000_0000);
        add_lookup(4'd0, 1'b0, '0);
        add_lookup(4'd1, 1'b0, '0);
        add_lookup(4'd2, 1'b0, '0);
        add_lookup(4'd4, 1'b0, '0);
        add_write(REG_FLAGS, ADDR_W'(FLAGS_ALL));
        add_lookup(4'd9, 1'b0, '0);
        add_lookup(4'd0, 1'b0, '0);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_WRITE) begin
                drain_results();
                write_reg(stim_rows[r].reg_index, stim_rows[r].data);
            end else begin
                send_level(stim_rows[r].level, stim_rows[r].typed, stim_rows[r].desc);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 23;
                    recv_idle = 45;
                end
                1: begin
                    send_idle = 45;
                    recv_idle = 23;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                drain_results();
                program_setting(s);
                settings_done++;
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    if (n == ITEMS_PER_SETTING / 2 && s % 3 == 0) begin
                        drain_results();
                    end
                    send_level(random_level(), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Run covered %0d level lookups and %0d register writes over %0d register settings,",
                 lookups_seen, writes_seen, settings_done);
        $display("with sender and receiver stalls in both ratios and at full rate.");
        if (failures == 0 && desc_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
